// File: hw/rtl/tvsd_pkg.sv
`timescale 1ns / 1ps

package tvsd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned KindWidth  = 3;
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned CountWidth = 32;
   localparam int unsigned ErrWidth   = 2;
   localparam int unsigned PosWidth   = 3;

   typedef enum logic [2:0] {
      PH_KIND   = 3'd0,
      PH_SCALAR = 3'd1,
      PH_LENGTH = 3'd2,
      PH_STRING = 3'd3,
      PH_VECTOR = 3'd4
   } phase_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_NULL    = 3'd0,
      KIND_BOOLEAN = 3'd1,
      KIND_INT32   = 3'd2,
      KIND_INT64   = 3'd3,
      KIND_FLOAT32 = 3'd4,
      KIND_FLOAT64 = 3'd5,
      KIND_STRING  = 3'd6,
      KIND_VECTOR  = 3'd7
   } kind_type;

   typedef enum logic [ErrWidth-1:0] {
      ERR_NONE    = 2'd0,
      ERR_INVALID = 2'd1,
      ERR_ENDED   = 2'd2
   } err_type;

   typedef struct packed {
      logic [KindWidth-1:0]  value_kind;
      logic [ValueWidth-1:0] piece_value;
      logic                  has_piece;
      logic                  piece_last;
      logic [CountWidth-1:0] value_count;
      err_type               error_code;
   } result_type;

   // payload bytes of a scalar kind
   function automatic logic [3:0] scalar_bytes(input logic [KindWidth-1:0] kind);
      logic [3:0] need;
      case (kind)
         KIND_BOOLEAN: need = 4'd1;
         KIND_INT32:   need = 4'd4;
         KIND_INT64:   need = 4'd8;
         KIND_FLOAT32: need = 4'd4;
         KIND_FLOAT64: need = 4'd8;
         default:      need = 4'd0;
      endcase
      return need;
   endfunction

endpackage

// File: hw/rtl/tvsd_core.sv
`timescale 1ns / 1ps

module tvsd_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 take,
   input  logic [tvsd_pkg::ByteWidth-1:0]       in_byte,
   input  logic                                 stream_end,
   output logic                                 emit,
   output tvsd_pkg::result_type                 result
);
   import tvsd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [KindWidth-1:0]  kind_ff, kind_in;
   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic [ValueWidth-1:0] asm_ff, asm_in;
   logic [CountWidth-1:0] len_ff, len_in;
   logic [CountWidth-1:0] rem_ff, rem_in;

   logic [ValueWidth-1:0] asm_or;
   logic [CountWidth-1:0] rem_dec;
   logic [3:0]            need;
   logic [3:0]            pos_next;
   logic                  bad_kind;

   assign asm_or   = asm_ff | ({{(ValueWidth-ByteWidth){1'b0}}, in_byte} << {pos_ff, 3'b000});
   assign rem_dec  = rem_ff - {{(CountWidth-1){1'b0}}, 1'b1};
   assign need     = scalar_bytes(kind_ff);
   assign pos_next = {1'b0, pos_ff} + 4'd1;
   assign bad_kind = (in_byte > {{(ByteWidth-KindWidth){1'b0}}, {KindWidth{1'b1}}});

   // next state
   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      pos_in   = pos_ff;
      asm_in   = asm_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      if (take) begin
         unique case (phase_ff)
            PH_SCALAR, PH_LENGTH, PH_STRING, PH_VECTOR: begin
               if (stream_end) begin
                  phase_in = PH_KIND;
                  pos_in   = '0;
                  asm_in   = '0;
               end else begin
                  unique case (phase_ff)
                     PH_SCALAR: begin
                        if (need == 4'd0 || pos_next < need) begin
                           pos_in = pos_next[PosWidth-1:0];
                           asm_in = asm_or;
                        end else begin
                           phase_in = PH_KIND;
                           pos_in   = '0;
                           asm_in   = '0;
                        end
                     end
                     PH_LENGTH: begin
                        if (pos_ff < 3'd3) begin
                           pos_in = pos_next[PosWidth-1:0];
                           asm_in = asm_or;
                        end else begin
                           len_in = asm_or[CountWidth-1:0];
                           rem_in = asm_or[CountWidth-1:0];
                           pos_in = '0;
                           asm_in = '0;
                           if (asm_or[CountWidth-1:0] == '0) begin
                              phase_in = PH_KIND;
                           end else if (kind_ff == KIND_VECTOR) begin
                              phase_in = PH_VECTOR;
                           end else begin
                              phase_in = PH_STRING;
                           end
                        end
                     end
                     PH_STRING: begin
                        rem_in = rem_dec;
                        if (rem_dec == '0) begin
                           phase_in = PH_KIND;
                           pos_in   = '0;
                           asm_in   = '0;
                        end
                     end
                     default: begin
                        if (pos_ff != 3'd7) begin
                           pos_in = pos_next[PosWidth-1:0];
                           asm_in = asm_or;
                        end else begin
                           rem_in = rem_dec;
                           pos_in = '0;
                           asm_in = '0;
                           if (rem_dec == '0) begin
                              phase_in = PH_KIND;
                           end
                        end
                     end
                  endcase
               end
            end
            default: begin
               phase_in = PH_KIND;
               if (!stream_end) begin
                  pos_in = '0;
                  asm_in = '0;
                  if (!bad_kind) begin
                     kind_in = in_byte[KindWidth-1:0];
                     if (in_byte[KindWidth-1:0] == KIND_NULL) begin
                        phase_in = PH_KIND;
                     end else if (in_byte[KindWidth-1:0] == KIND_STRING ||
                                  in_byte[KindWidth-1:0] == KIND_VECTOR) begin
                        phase_in = PH_LENGTH;
                     end else begin
                        phase_in = PH_SCALAR;
                     end
                  end
               end
            end
         endcase
      end
   end

   // result
   always_comb begin
      emit               = 1'b0;
      result.value_kind  = kind_ff;
      result.piece_value = '0;
      result.has_piece   = 1'b0;
      result.piece_last  = 1'b1;
      result.value_count = '0;
      result.error_code  = ERR_NONE;
      unique case (phase_ff)
         PH_SCALAR, PH_LENGTH, PH_STRING, PH_VECTOR: begin
            if (stream_end) begin
               emit              = 1'b1;
               result.error_code = ERR_ENDED;
            end else begin
               unique case (phase_ff)
                  PH_SCALAR: begin
                     emit = (need != 4'd0) && (pos_next >= need);
                     result.has_piece = 1'b1;
                     if (kind_ff == KIND_BOOLEAN) begin
                        result.piece_value = {{(ValueWidth-1){1'b0}}, (asm_or != '0)};
                     end else if (kind_ff == KIND_INT32) begin
                        result.piece_value = {{(ValueWidth-32){asm_or[31]}}, asm_or[31:0]};
                     end else begin
                        result.piece_value = asm_or;
                     end
                  end
                  PH_LENGTH: begin
                     emit = (pos_ff == 3'd3) && (asm_or[CountWidth-1:0] == '0);
                  end
                  PH_STRING: begin
                     emit               = 1'b1;
                     result.value_kind  = KIND_STRING;
                     result.piece_value = {{(ValueWidth-ByteWidth){1'b0}}, in_byte};
                     result.has_piece   = 1'b1;
                     result.piece_last  = (rem_dec == '0);
                     result.value_count = len_ff;
                  end
                  default: begin
                     emit               = (pos_ff == 3'd7);
                     result.value_kind  = KIND_VECTOR;
                     result.piece_value = asm_or;
                     result.has_piece   = 1'b1;
                     result.piece_last  = (rem_dec == '0);
                     result.value_count = len_ff;
                  end
               endcase
            end
         end
         default: begin
            if (!stream_end) begin
               if (bad_kind) begin
                  emit              = 1'b1;
                  result.value_kind = KIND_NULL;
                  result.error_code = ERR_INVALID;
               end else if (in_byte[KindWidth-1:0] == KIND_NULL) begin
                  emit              = 1'b1;
                  result.value_kind = KIND_NULL;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KIND;
         kind_ff  <= '0;
         pos_ff   <= '0;
         asm_ff   <= '0;
         len_ff   <= '0;
         rem_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         pos_ff   <= pos_in;
         asm_ff   <= asm_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

// File: hw/rtl/tagged_value_stream_decoder_unit.sv
`timescale 1ns / 1ps

// tagged value stream decoder
// req channel: one byte of the encoded stream per request in req_tdata;
//   req_tuser high means the data has ended (no byte in that request)
// rsp channel: at most one decoded result per request; tlast marks the
//   final piece of a value, tuser carries kind, piece flag and error code
// each value opens with a kind byte; scalars give one result once their
//   little-endian bytes are in, strings and vectors give one result per
//   byte or per 8-byte element after a 4-byte length
// a result is presented from the output register in the cycle after the request
//   that completes it is accepted
// throughput: one request per cycle unless stalled; the decode is a byte shift-in,
//   a count and a compare between the state registers and the output register
// when the receiver stalls, the output register holds its result and
//   req_tready drops only while that register is full and not taken
// reset clears the decoder to waiting for a kind byte and empties the
//   output register
module tagged_value_stream_decoder_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // in_byte
   input  logic [0:0]                           req_tuser,  // stream_end
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [95:0]                          rsp_tdata,  // piece_value, value_count
   output logic [5:0]                           rsp_tuser,  // value_kind, has_piece, error_code
   output logic                                 rsp_tlast   // piece_last
);
   import tvsd_pkg::*;

   logic       take;
   logic       emit;
   result_type result;
   result_type out_ff;
   logic       valid_ff, valid_in;

   assign req_tready = !valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   tvsd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .in_byte    (req_tdata),
      .stream_end (req_tuser[0]),
      .emit       (emit),
      .result     (result)
   );

   always_comb begin
      if (take && emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {out_ff.value_count, out_ff.piece_value};
   assign rsp_tuser  = {out_ff.error_code, out_ff.has_piece, out_ff.value_kind};
   assign rsp_tlast  = out_ff.piece_last;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result present right after reset");
   a_ready_when_empty: assert property (@(posedge clock) !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output register");
   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[5:4] != ERR_NONE |-> rsp_tlast && !rsp_tuser[3])
      else $error("error result not final or carries a piece");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[3] |-> rsp_tdata[63:0] == '0 && rsp_tlast)
      else $error("result without piece carries data");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tvsd_pkg::*;

   localparam int unsigned CycleLimit = 500000;
   localparam int unsigned RandomRequests = 1600;

   typedef struct {
      logic [7:0] data;
      logic       ended;
      bit         drain;
   } stream_byte_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic [5:0]  rsp_tuser;
   logic        rsp_tlast;

   stream_byte_type stream_bytes[$];
   result_type      expected_pieces[$];
   bit           drain_next;
   bit           req_busy;
   int           req_gap;
   int           rsp_stall;
   int unsigned  requests_taken;
   int unsigned  results_seen;
   int unsigned  invalid_seen;
   int unsigned  truncated_seen;
   int unsigned  mismatches;
   int unsigned  cycles;

   // decoder image
   phase_type   dec_phase;
   kind_type    dec_kind;
   logic [2:0]  dec_pos;
   logic [63:0] dec_word;
   logic [31:0] dec_len;
   logic [31:0] dec_left;

   tagged_value_stream_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int payload_bytes(input kind_type k);
      case (k)
         KIND_BOOLEAN:              return 1;
         KIND_INT32, KIND_FLOAT32:  return 4;
         KIND_INT64, KIND_FLOAT64:  return 8;
         default:                   return 0;
      endcase
   endfunction

   function automatic int pause_len(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   task automatic decoder_idle();
      dec_phase = PH_KIND;
      dec_pos = '0;
      dec_word = '0;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic ended,
                              output bit emit, output result_type r);
      logic [63:0] v;
      r = '0;
      r.error_code = ERR_NONE;
      r.piece_last = 1'b1;
      emit = 1'b0;
      if (dec_phase == PH_KIND) begin
         if (!ended) begin
            if (b > 8'd7) begin
               emit = 1'b1;
               r.error_code = ERR_INVALID;
               decoder_idle();
            end else begin
               dec_kind = kind_type'(b[2:0]);
               dec_pos = '0;
               dec_word = '0;
               if (dec_kind == KIND_NULL) begin
                  emit = 1'b1;
                  r.value_kind = KIND_NULL;
               end else if (dec_kind == KIND_STRING || dec_kind == KIND_VECTOR) begin
                  dec_phase = PH_LENGTH;
               end else begin
                  dec_phase = PH_SCALAR;
               end
            end
         end
      end else if (ended) begin
         emit = 1'b1;
         r.value_kind = dec_kind;
         r.error_code = ERR_ENDED;
         decoder_idle();
      end else if (dec_phase == PH_STRING) begin
         dec_left = dec_left - 32'd1;
         emit = 1'b1;
         r.value_kind = KIND_STRING;
         r.piece_value = {56'd0, b};
         r.has_piece = 1'b1;
         r.piece_last = (dec_left == 32'd0);
         r.value_count = dec_len;
         if (dec_left == 32'd0) decoder_idle();
      end else begin
         dec_word = dec_word | ({56'd0, b} << (8 * dec_pos));
         case (dec_phase)
            PH_SCALAR: begin
               if (int'(dec_pos) + 1 < payload_bytes(dec_kind)) begin
                  dec_pos = dec_pos + 3'd1;
               end else begin
                  v = dec_word;
                  if (dec_kind == KIND_BOOLEAN) v = (v != 64'd0) ? 64'd1 : 64'd0;
                  else if (dec_kind == KIND_INT32 && v[31]) v[63:32] = '1;
                  emit = 1'b1;
                  r.value_kind = dec_kind;
                  r.piece_value = v;
                  r.has_piece = 1'b1;
                  decoder_idle();
               end
            end
            PH_LENGTH: begin
               if (dec_pos < 3'd3) begin
                  dec_pos = dec_pos + 3'd1;
               end else begin
                  dec_len = dec_word[31:0];
                  dec_left = dec_len;
                  dec_pos = '0;
                  dec_word = '0;
                  if (dec_len == 32'd0) begin
                     emit = 1'b1;
                     r.value_kind = dec_kind;
                     decoder_idle();
                  end else begin
                     dec_phase = (dec_kind == KIND_VECTOR) ? PH_VECTOR : PH_STRING;
                  end
               end
            end
            default: begin
               if (dec_pos < 3'd7) begin
                  dec_pos = dec_pos + 3'd1;
               end else begin
                  dec_left = dec_left - 32'd1;
                  emit = 1'b1;
                  r.value_kind = KIND_VECTOR;
                  r.piece_value = dec_word;
                  r.has_piece = 1'b1;
                  r.piece_last = (dec_left == 32'd0);
                  r.value_count = dec_len;
                  dec_pos = '0;
                  dec_word = '0;
                  if (dec_left == 32'd0) decoder_idle();
               end
            end
         endcase
      end
   endtask

   task automatic add_byte(input logic [7:0] b, input logic ended);
      stream_byte_type s;
      s.data = b;
      s.ended = ended;
      s.drain = drain_next;
      drain_next = 1'b0;
      stream_bytes.insert(stream_bytes.size(), s);
   endtask

   // cut 0: whole value, cut -1: end of stream at a random point, else after cut bytes
   task automatic add_value(input kind_type k, input logic [63:0] payload,
                            input logic [31:0] len, input int cut);
      logic [7:0] seq[$];
      int n;
      int stop;
      seq.insert(seq.size(), 8'(k));
      if (k == KIND_STRING || k == KIND_VECTOR) begin
         for (int i = 0; i < 4; i++) seq.insert(seq.size(), len[8*i +: 8]);
         n = (len > 32'd64) ? 16 : int'(len) * ((k == KIND_VECTOR) ? 8 : 1);
         for (int i = 0; i < n; i++) seq.insert(seq.size(), 8'($urandom_range(0, 255)));
      end else begin
         for (int i = 0; i < payload_bytes(k); i++) seq.insert(seq.size(), payload[8*i +: 8]);
      end
      stop = seq.size();
      if (cut < 0) stop = $urandom_range(1, seq.size());
      else if (cut > 0 && cut < seq.size()) stop = cut;
      for (int i = 0; i < stop; i++) add_byte(seq[i], 1'b0);
      if (cut != 0) add_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [63:0] random_payload(input kind_type k);
      logic [63:0] v;
      int r;
      r = $urandom_range(0, 9);
      v = {$urandom, $urandom};
      if (r == 0) v = '0;
      else if (r == 1) v = '1;
      else if (r == 2) v = {1'b1, 31'd0, 1'b1, 31'd0};
      else if (r == 3) v = {33'd0, 31'h7fff_ffff};
      if (k == KIND_BOOLEAN && $urandom_range(0, 1) == 0) v = '0;
      return v;
   endfunction

   task automatic add_random_value(input bit broken);
      kind_type    k;
      logic [31:0] len;
      k = kind_type'($urandom_range(0, 7));
      len = '0;
      if (k == KIND_STRING)
         len = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(9, 40))
                                           : 32'($urandom_range(0, 8));
      else if (k == KIND_VECTOR)
         len = 32'($urandom_range(0, 4));
      if (broken && (k == KIND_STRING || k == KIND_VECTOR) && $urandom_range(0, 2) == 0)
         len = $urandom | 32'h0100_0000;
      add_value(k, random_payload(k), len, broken ? -1 : 0);
   endtask

   initial begin
      int r;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      drain_next = 1'b0;
      req_busy = 1'b0;
      req_gap = 0;
      rsp_stall = 0;
      requests_taken = 0;
      results_seen = 0;
      invalid_seen = 0;
      truncated_seen = 0;
      mismatches = 0;
      dec_kind = KIND_NULL;
      dec_len = '0;
      dec_left = '0;
      decoder_idle();

      // directed values
      add_value(KIND_NULL, '0, '0, 0);
      add_value(KIND_BOOLEAN, 64'h00, '0, 0);
      add_value(KIND_BOOLEAN, 64'h80, '0, 0);
      add_value(KIND_INT32, 64'h7fff_ffff, '0, 0);
      add_value(KIND_INT32, 64'h8000_0000, '0, 0);
      add_value(KIND_INT64, 64'h8000_0000_0000_0001, '0, 0);
      add_value(KIND_FLOAT32, 64'hff80_0001, '0, 0);
      add_value(KIND_FLOAT64, '1, '0, 0);
      add_value(KIND_STRING, '0, 32'd0, 0);
      add_value(KIND_STRING, '0, 32'd3, 0);
      add_value(KIND_VECTOR, '0, 32'd0, 0);
      add_value(KIND_VECTOR, '0, 32'd2, 0);
      add_byte(8'd8, 1'b0);
      add_byte(8'd255, 1'b0);
      add_byte(8'hff, 1'b1);
      add_value(KIND_INT64, '1, '0, 4);
      add_value(KIND_STRING, '0, 32'hffff_ffff, 3);
      add_value(KIND_STRING, '0, 32'd5, 7);
      add_value(KIND_VECTOR, '0, 32'd3, 12);
      add_value(KIND_VECTOR, '0, 32'hffff_ffff, 9);

      // random traffic, pausing for the decoder to drain now and then
      drain_next = 1'b1;
      r = stream_bytes.size();
      while (stream_bytes.size() < r + RandomRequests) begin
         if ((stream_bytes.size() - r) % 500 < 8 && stream_bytes.size() - r > 8)
            drain_next = 1'b1;
         case ($urandom_range(0, 99)) inside
            [0:77]:  add_random_value(1'b0);
            [78:87]: add_byte(8'($urandom_range(8, 255)), 1'b0);
            [88:97]: add_random_value(1'b1);
            default: add_byte(8'($urandom_range(0, 255)), 1'b1);
         endcase
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (stream_bytes.size() != 0 || req_busy || expected_pieces.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d requests and %0d results, %0d invalid kind bytes, %0d cut-off values",
               requests_taken, results_seen, invalid_seen, truncated_seen);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      stream_byte_type s;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_busy) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (stream_bytes.size() != 0 &&
                      !(stream_bytes[0].drain && expected_pieces.size() != 0)) begin
            s = stream_bytes.pop_front();
            req_tdata <= s.data;
            req_tuser <= s.ended;
            req_tvalid <= 1'b1;
            req_busy = 1'b1;
            req_gap = pause_len((requests_taken / 128) % 4 == 3);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready
   always @(negedge clock) begin
      rsp_tready <= (rsp_stall == 0);
      if (rsp_stall > 0) rsp_stall--;
      else if ($urandom_range(0, 2) == 0) rsp_stall = pause_len((results_seen / 128) % 4 == 1);
   end

   // request and response monitor
   always @(posedge clock) begin
      bit         emit;
      result_type want;
      result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_busy = 1'b0;
            requests_taken++;
            decode_byte(req_tdata, req_tuser[0], emit, want);
            if (emit) begin
               expected_pieces.insert(expected_pieces.size(), want);
               if (want.error_code == ERR_INVALID) invalid_seen++;
               if (want.error_code == ERR_ENDED) truncated_seen++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got = '0;
            got.value_kind = rsp_tuser[2:0];
            got.has_piece = rsp_tuser[3];
            got.error_code = err_type'(rsp_tuser[5:4]);
            got.piece_value = rsp_tdata[63:0];
            got.value_count = rsp_tdata[95:64];
            got.piece_last = rsp_tlast;
            if (expected_pieces.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with none pending: kind %0d value %h count %0d err %0d",
                           $realtime, got.value_kind, got.piece_value, got.value_count,
                           got.error_code);
            end else begin
               want = expected_pieces.pop_front();
               if (got.value_kind !== want.value_kind || got.piece_value !== want.piece_value ||
                   got.has_piece !== want.has_piece || got.piece_last !== want.piece_last ||
                   got.value_count !== want.value_count ||
                   got.error_code !== want.error_code) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: expected kind %0d value %h has %0b last %0b count %0d err %0d",
                              $realtime, want.value_kind, want.piece_value, want.has_piece,
                              want.piece_last, want.value_count, want.error_code);
                     $display("%0t: actual   kind %0d value %h has %0b last %0b count %0d err %0d",
                              $realtime, got.value_kind, got.piece_value, got.has_piece,
                              got.piece_last, got.value_count, got.error_code);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  expected_pieces.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
